>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, quiet while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same, for an implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, cond, expect_expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_expr)) \
      else $error(msg);

`endif

>>> sv/jnq_pkg.sv
package jnq_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int TIME_BITS     = 32;
   localparam int REPEAT_BITS   = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [SAMPLE_BITS-1:0] DEAD_LOW_RESET  = SAMPLE_BITS'(1800);
   localparam logic [SAMPLE_BITS-1:0] DEAD_HIGH_RESET = SAMPLE_BITS'(2200);
   localparam logic [REPEAT_BITS-1:0] REPEAT_RESET    = REPEAT_BITS'(150);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [1:0]      step_type;

   localparam step_type STEP_NEG  = 2'sb11;
   localparam step_type STEP_ZERO = 2'sb00;
   localparam step_type STEP_POS  = 2'sb01;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEAD_LOW  = 2'd0,
      CSR_DEAD_HIGH = 2'd1,
      CSR_REPEAT_MS = 2'd2
   } csr_index_type;

endpackage

>>> sv/joystick_navigation_qualifier.sv
// Joystick navigation qualifier: takes one poll sample per clock and returns one result
// beat per sample, through one input register and one result register.
// The result register frees the input side, so a new sample is taken while a result waits
// to be drained; throughput drops below one per cycle only while rsp_stall holds the
// result. Registers are written through the csr_ port, which is always ready and must be
// used only while no sample is in flight. Index 0 dead_low, 1 dead_high, 2 repeat_ms;
// index 3 is ignored.
`include "assert_macros.svh"

module joystick_navigation_qualifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [jnq_pkg::SAMPLE_BITS-1:0]       req_stick_x,
   input  logic [jnq_pkg::SAMPLE_BITS-1:0]       req_stick_y,
   input  logic                                  req_switch_level,
   input  logic                                  req_start_event,
   input  logic                                  req_ok_event,
   input  logic                                  req_back_event,
   input  logic [jnq_pkg::TIME_BITS-1:0]         req_now_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_switch_press,
   output logic                                  rsp_start_press,
   output logic                                  rsp_ok_press,
   output logic                                  rsp_back_press,
   output logic signed [1:0]                     rsp_step_x,
   output logic signed [1:0]                     rsp_step_y,
   output logic                                  rsp_move_up,
   output logic                                  rsp_move_down,
   output logic                                  rsp_move_left,
   output logic                                  rsp_move_right,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jnq_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [jnq_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import jnq_pkg::*;

   // configuration
   sample_type             dead_low_ff, dead_high_ff;
   logic [REPEAT_BITS-1:0] repeat_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_low_ff  <= DEAD_LOW_RESET;
         dead_high_ff <= DEAD_HIGH_RESET;
         repeat_ms_ff <= REPEAT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEAD_LOW:  dead_low_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_DEAD_HIGH: dead_high_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_REPEAT_MS: repeat_ms_ff <= csr_data[REPEAT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                 s1_valid_ff;
   sample_type           s1_x_ff, s1_y_ff;
   logic                 s1_sw_ff, s1_start_ff, s1_ok_ff, s1_back_ff;
   logic [TIME_BITS-1:0] s1_now_ff;

   logic out_valid_ff;
   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_x_ff     <= req_stick_x;
         s1_y_ff     <= req_stick_y;
         s1_sw_ff    <= req_switch_level;
         s1_start_ff <= req_start_event;
         s1_ok_ff    <= req_ok_event;
         s1_back_ff  <= req_back_event;
         s1_now_ff   <= req_now_ms;
      end
   end

   // qualification logic
   function automatic step_type axis_step(sample_type v, sample_type lo, sample_type hi);
      step_type s;
      if (v < lo)      s = STEP_NEG;
      else if (v > hi) s = STEP_POS;
      else             s = STEP_ZERO;
      return s;
   endfunction

   logic                 prev_switch_ff;
   logic [TIME_BITS-1:0] last_nav_time_ff;

   step_type             step_x_in, step_y_in;
   logic                 edge_in;
   logic [TIME_BITS-1:0] elapsed;
   logic                 expired;
   logic                 up_in, down_in, left_in, right_in, nav_any;

   always_comb begin
      step_x_in = axis_step(s1_x_ff, dead_low_ff, dead_high_ff);
      step_y_in = axis_step(s1_y_ff, dead_low_ff, dead_high_ff);
      edge_in   = s1_sw_ff && !prev_switch_ff;
      elapsed   = s1_now_ff - last_nav_time_ff;   // wraps mod 2^32
      expired   = elapsed > TIME_BITS'(repeat_ms_ff);
      up_in     = expired && (step_y_in == STEP_NEG);
      down_in   = expired && (step_y_in == STEP_POS);
      left_in   = expired && (step_y_in == STEP_ZERO) && (step_x_in == STEP_NEG);
      right_in  = expired && (step_y_in == STEP_ZERO) && (step_x_in == STEP_POS);
      nav_any   = up_in || down_in || left_in || right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_switch_ff   <= 1'b0;
         last_nav_time_ff <= '0;
      end else if (advance) begin
         prev_switch_ff <= s1_sw_ff;
         if (nav_any) begin
            last_nav_time_ff <= s1_now_ff;
         end
      end
   end

   // result register
   logic     out_switch_ff, out_start_ff, out_ok_ff, out_back_ff;
   step_type out_step_x_ff, out_step_y_ff;
   logic     out_up_ff, out_down_ff, out_left_ff, out_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_switch_ff <= edge_in;
         out_start_ff  <= s1_start_ff;
         out_ok_ff     <= s1_ok_ff || edge_in;
         out_back_ff   <= s1_back_ff;
         out_step_x_ff <= step_x_in;
         out_step_y_ff <= step_y_in;
         out_up_ff     <= up_in;
         out_down_ff   <= down_in;
         out_left_ff   <= left_in;
         out_right_ff  <= right_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_switch_press = out_switch_ff;
   assign rsp_start_press  = out_start_ff;
   assign rsp_ok_press     = out_ok_ff;
   assign rsp_back_press   = out_back_ff;
   assign rsp_step_x       = out_step_x_ff;
   assign rsp_step_y       = out_step_y_ff;
   assign rsp_move_up      = out_up_ff;
   assign rsp_move_down    = out_down_ff;
   assign rsp_move_left    = out_left_ff;
   assign rsp_move_right   = out_right_ff;

   // checks
   `ASSERT_CLK(a_nav_onehot, !rsp_valid || $onehot0({out_up_ff, out_down_ff, out_left_ff, out_right_ff}), "two moves")
   `ASSERT_CLK(a_up_needs_step, !(rsp_valid && rsp_move_up) || (rsp_step_y == STEP_NEG), "up without step")
   `ASSERT_NEXT(a_nav_restarts, advance && nav_any, last_nav_time_ff == $past(s1_now_ff), "no restart")
   `ASSERT_CLK(a_edge_in_ok, !(rsp_valid && rsp_switch_press) || rsp_ok_press, "edge not in ok")

endmodule

>>> tb/sv/tb_joystick_navigation_qualifier.sv
`timescale 1ns / 100ps

module tb_joystick_navigation_qualifier;
   import jnq_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 60;

   typedef struct packed {
      sample_type             stick_x;
      sample_type             stick_y;
      logic                   switch_level;
      logic                   start_event;
      logic                   ok_event;
      logic                   back_event;
      logic [TIME_BITS-1:0]   now_ms;
   } poll_type;

   typedef struct packed {
      logic       switch_press;
      logic       start_press;
      logic       ok_press;
      logic       back_press;
      step_type   step_x;
      step_type   step_y;
      logic       move_up;
      logic       move_down;
      logic       move_left;
      logic       move_right;
   } nav_result_type;

   class nav_scoreboard_type;
      sample_type             dead_low;
      sample_type             dead_high;
      logic [REPEAT_BITS-1:0] repeat_ms;
      logic                   prev_switch;
      logic [TIME_BITS-1:0]   last_nav_ms;
      nav_result_type         expected_q[$];
      int                     errors;

      function new();
         dead_low    = DEAD_LOW_RESET;
         dead_high   = DEAD_HIGH_RESET;
         repeat_ms   = REPEAT_RESET;
         prev_switch = 1'b0;
         last_nav_ms = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_DEAD_LOW:  dead_low  = data[SAMPLE_BITS-1:0];
            CSR_DEAD_HIGH: dead_high = data[SAMPLE_BITS-1:0];
            CSR_REPEAT_MS: repeat_ms = data[REPEAT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // below-low test first, so a crossed zone resolves to negative
      function step_type axis_step(sample_type v);
         if (v < dead_low) return STEP_NEG;
         if (v > dead_high) return STEP_POS;
         return STEP_ZERO;
      endfunction

      function void note_poll(poll_type p);
         nav_result_type       r;
         logic [TIME_BITS-1:0] elapsed;
         r = '0;
         r.switch_press = p.switch_level & ~prev_switch;
         r.start_press  = p.start_event;
         r.ok_press     = p.ok_event | r.switch_press;
         r.back_press   = p.back_event;
         r.step_x       = axis_step(p.stick_x);
         r.step_y       = axis_step(p.stick_y);
         prev_switch    = p.switch_level;
         elapsed        = p.now_ms - last_nav_ms;
         if (elapsed > TIME_BITS'(repeat_ms)) begin
            if (r.step_y == STEP_NEG) r.move_up = 1'b1;
            else if (r.step_y == STEP_POS) r.move_down = 1'b1;
            else if (r.step_x == STEP_NEG) r.move_left = 1'b1;
            else if (r.step_x == STEP_POS) r.move_right = 1'b1;
            // idle stick leaves the interval running
            if (r.move_up | r.move_down | r.move_left | r.move_right) last_nav_ms = p.now_ms;
         end
         expected_q.push_back(r);
      endfunction

      function string fmt(nav_result_type r);
         return $sformatf("sw=%b start=%b ok=%b back=%b sx=%0d sy=%0d u/d/l/r=%b%b%b%b",
                          r.switch_press, r.start_press, r.ok_press, r.back_press,
                          r.step_x, r.step_y, r.move_up, r.move_down, r.move_left,
                          r.move_right);
      endfunction

      function void check_result(nav_result_type got);
         nav_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR: result beat with nothing expected: %s", fmt(got));
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("ERROR: result mismatch");
               $display("   expected %s", fmt(want));
               $display("   actual   %s", fmt(got));
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SAMPLE_BITS-1:0]   req_stick_x = '0;
   logic [SAMPLE_BITS-1:0]   req_stick_y = '0;
   logic                     req_switch_level = 1'b0;
   logic                     req_start_event = 1'b0;
   logic                     req_ok_event = 1'b0;
   logic                     req_back_event = 1'b0;
   logic [TIME_BITS-1:0]     req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_switch_press;
   logic                     rsp_start_press;
   logic                     rsp_ok_press;
   logic                     rsp_back_press;
   logic signed [1:0]        rsp_step_x;
   logic signed [1:0]        rsp_step_y;
   logic                     rsp_move_up;
   logic                     rsp_move_down;
   logic                     rsp_move_left;
   logic                     rsp_move_right;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   nav_scoreboard_type   sb = new();
   bit                   idle_on = 1'b1;
   logic                 hold_on = 1'b0;
   int                   stall_left = 0;
   int                   accepted_count = 0;
   logic [TIME_BITS-1:0] ms_clock = '0;
   logic                 switch_now = 1'b0;

   joystick_navigation_qualifier uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .req_switch_level (req_switch_level),
      .req_start_event  (req_start_event),
      .req_ok_event     (req_ok_event),
      .req_back_event   (req_back_event),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_switch_press (rsp_switch_press),
      .rsp_start_press  (rsp_start_press),
      .rsp_ok_press     (rsp_ok_press),
      .rsp_back_press   (rsp_back_press),
      .rsp_step_x       (rsp_step_x),
      .rsp_step_y       (rsp_step_y),
      .rsp_move_up      (rsp_move_up),
      .rsp_move_down    (rsp_move_down),
      .rsp_move_left    (rsp_move_left),
      .rsp_move_right   (rsp_move_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      return idle_on ? int'($urandom_range(0, 3)) : 0;
   endfunction

   // receiver: random stall after each beat, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_on) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = pick_gap();
         else if (stall_left > 0) stall_left--;
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      wait (accepted_count >= HOLD_AFTER);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin : watch_results
      nav_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.switch_press = rsp_switch_press;
         got.start_press  = rsp_start_press;
         got.ok_press     = rsp_ok_press;
         got.back_press   = rsp_back_press;
         got.step_x       = rsp_step_x;
         got.step_y       = rsp_step_y;
         got.move_up      = rsp_move_up;
         got.move_down    = rsp_move_down;
         got.move_left    = rsp_move_left;
         got.move_right   = rsp_move_right;
         sb.check_result(got);
      end
   end

   // leaves valid high on return; the caller either sends again or lowers it
   task automatic send_poll(poll_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_stick_x      <= p.stick_x;
      req_stick_y      <= p.stick_y;
      req_switch_level <= p.switch_level;
      req_start_event  <= p.start_event;
      req_ok_event     <= p.ok_event;
      req_back_event   <= p.back_event;
      req_now_ms       <= p.now_ms;
      do @(posedge clock); while (req_stall);
      sb.note_poll(p);
      accepted_count++;
   endtask

   task automatic send_fields(int x, int y, bit sw, bit st, bit ok, bit bk,
                              logic [TIME_BITS-1:0] now);
      poll_type p;
      p.stick_x      = sample_type'(x);
      p.stick_y      = sample_type'(y);
      p.switch_level = sw;
      p.start_event  = st;
      p.ok_event     = ok;
      p.back_event   = bk;
      p.now_ms       = now;
      send_poll(p);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // only with the pipe empty; upper data bits are junk the block must drop
   task automatic write_config(int lo, int hi, int rep);
      logic [CSR_DATA_BITS-1:0] junk;
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      junk = CSR_DATA_BITS'($urandom);
      write_reg(CSR_DEAD_LOW, {junk[15:12], sample_type'(lo)});
      junk = CSR_DATA_BITS'($urandom);
      write_reg(CSR_DEAD_HIGH, {junk[15:12], sample_type'(hi)});
      write_reg(CSR_REPEAT_MS, CSR_DATA_BITS'(rep));
      write_reg(CSR_SPARE_INDEX, CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic sample_type pick_axis();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 4095;
         2: v = int'(sb.dead_low) + int'($urandom_range(0, 2)) - 1;
         3: v = int'(sb.dead_high) + int'($urandom_range(0, 2)) - 1;
         4: v = (int'(sb.dead_low) + int'(sb.dead_high)) / 2;
         default: v = int'($urandom_range(0, 4095));
      endcase
      return sample_type'(v);
   endfunction

   task automatic random_phase(int count);
      poll_type p;
      int       span;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
         span = int'(sb.repeat_ms) * 2 + 4;
         if ($urandom_range(0, 15) == 0) ms_clock = $urandom;
         else ms_clock = ms_clock + TIME_BITS'($urandom_range(0, span));
         if ($urandom_range(0, 2) == 0) switch_now = ~switch_now;
         p.stick_x      = pick_axis();
         p.stick_y      = pick_axis();
         p.switch_level = switch_now;
         p.start_event  = ($urandom_range(0, 3) == 0);
         p.ok_event     = ($urandom_range(0, 3) == 0);
         p.back_event   = ($urandom_range(0, 3) == 0);
         p.now_ms       = ms_clock;
         send_poll(p);
      end
   endtask

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: priority, strict interval, dead zone edges
      send_fields(2000, 2000, 0, 0, 0, 0, 0);
      send_fields(0, 0, 0, 0, 0, 0, 151);
      send_fields(0, 4095, 0, 0, 0, 0, 301);
      send_fields(0, 4095, 0, 0, 0, 0, 302);
      send_fields(0, 2000, 0, 0, 0, 0, 453);
      send_fields(4095, 2000, 0, 0, 0, 0, 604);
      send_fields(1799, 2000, 0, 0, 0, 0, 755);
      send_fields(1800, 2200, 0, 0, 0, 0, 5000);
      send_fields(2201, 2000, 0, 0, 0, 0, 5001);
      send_fields(2000, 1799, 0, 0, 0, 0, 5002);
      // switch edge and button beats
      send_fields(2000, 2000, 1, 0, 0, 0, 5003);
      send_fields(2000, 2000, 1, 0, 1, 0, 5004);
      send_fields(2000, 2000, 0, 1, 0, 1, 5005);
      send_fields(2000, 2000, 1, 1, 1, 1, 5006);
      // time wrap and now before last navigation
      send_fields(2000, 0, 0, 0, 0, 0, 32'hFFFF_FFF0);
      send_fields(2000, 0, 0, 0, 0, 0, 32'h0000_0005);
      send_fields(2000, 0, 0, 0, 0, 0, 200);
      send_fields(0, 2000, 0, 0, 0, 0, 100);
      // crossed dead zone, zero interval
      write_config(3000, 1000, 0);
      send_fields(2000, 2000, 0, 0, 0, 0, 100);
      send_fields(2000, 500, 0, 0, 0, 0, 101);
      send_fields(4095, 4095, 0, 0, 0, 0, 101);
      send_fields(4095, 4095, 0, 0, 0, 0, 102);

      write_config(DEAD_LOW_RESET, DEAD_HIGH_RESET, REPEAT_RESET);
      random_phase(200);
      write_config(0, 4095, 0);
      random_phase(60);
      write_config(4095, 0, 65535);
      random_phase(100);
      write_config(3000, 1000, $urandom_range(0, 300));
      random_phase(150);
      write_config($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
      ms_clock = 32'hFFFF_F000;
      random_phase(150);
      write_config($urandom_range(0, 2047), $urandom_range(2048, 4095), $urandom_range(0, 500));
      random_phase(150);
      write_config($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
      random_phase(140);

      req_valid <= 1'b0;
      waited = 0;
      while (sb.expected_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $display("ERROR: %0d expected results never arrived", sb.expected_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
